// File: sv/tld_pkg.sv
package tld_pkg;

	// default ring depth
	localparam int BUF_DEPTH_DEF = 256;

	// character codes
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] ERASE_RST = 8'h7F;
	localparam logic [7:0] EOF_RST = 8'h04;

	// commands
	localparam logic [1:0] CMD_RX = 2'd0;
	localparam logic [1:0] CMD_TX = 2'd1;
	localparam logic [1:0] CMD_RD = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SENT = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_CR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPOST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONLCR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CANON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHOE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_EOF = 3'd7;

	typedef logic [7:0] byte_t;

endpackage

// File: sv/terminal_line_discipline_top.sv
// Terminal line discipline for one terminal.
// Input channel (in_valid / in_stall) carries cmd and data_in: a received
// byte, a byte to write out, or a read request. The block raises in_stall
// while it works on an item; a transfer happens when in_valid is high and
// in_stall is low.
// Output channel (out_valid / out_stall) carries out_kind, out_byte,
// line_end and last; one item gives zero to three results, last marks the
// final one. Results sit in an output register, so a stalled receiver holds
// the current result while the block takes the next item.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes one
// register per transfer; cfg_ready is always high. Write only while idle.
// Sequence: the item is taken, then its results are loaded into the output
// register in order, waiting while the receiver stalls; a read first waits on
// the read memory. A newline or EOF in canonical mode walks the edit ring into
// the read ring, one byte a cycle out of the edit memory's read port.
// Reset clears pointers, counts and config to defaults at once; the two
// ring memories need no clearing pass since only counted bytes are read.
module terminal_line_discipline_top #(
	parameter int BUF_DEPTH = tld_pkg::BUF_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [7:0]                    data_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    out_kind,
	output logic [7:0]                    out_byte,
	output logic                          line_end,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(BUF_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUF_DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_COMMIT = 2'd1;
	localparam logic [1:0] S_RDWAIT = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q, state_d;

	// config registers
	logic map_cr_q, opost_q, onlcr_q, canon_q, echo_q, echoe_q;
	tld_pkg::byte_t erase_q, eof_q;

	// ring pointers
	logic [AW-1:0] edit_head_q, edit_head_d, edit_tail_q, edit_tail_d;
	logic [CW-1:0] edit_count_q, edit_count_d;
	logic [AW-1:0] read_head_q, read_head_d, read_tail_q, read_tail_d;
	logic [CW-1:0] read_count_q, read_count_d;

	// pending results of the current item
	tld_pkg::byte_t pend_byte_q [3];
	tld_pkg::byte_t pend_byte_d [3];
	logic [1:0] pend_n_q, pend_n_d, pend_idx_q, pend_idx_d;
	logic [1:0] pend_kind_q, pend_kind_d;
	logic       pend_le_q, pend_le_d;

	// commit pipeline: edit memory read in flight
	logic rd_v_s1, rd_v_d;

	// memories
	tld_pkg::byte_t edit_mem [BUF_DEPTH];
	tld_pkg::byte_t read_mem [BUF_DEPTH];
	tld_pkg::byte_t edit_rdata_q, read_rdata_q, edit_wdata, read_wdata;
	logic [AW-1:0] edit_waddr, edit_raddr, read_waddr, read_raddr;
	logic edit_we, edit_re, read_we, read_re;

	// output register
	logic out_valid_q, out_last_q, out_le_q, out_load;
	logic [1:0] out_kind_q;
	tld_pkg::byte_t out_byte_q;

	tld_pkg::byte_t rx_c;
	logic accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rx_c = (map_cr_q && data_in == tld_pkg::CH_CR) ? tld_pkg::CH_LF : data_in;

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_byte = out_byte_q;
	assign line_end = out_le_q;
	assign last = out_last_q;

	always_comb begin
		tld_pkg::byte_t post_b;
		logic post_go, commit;
		state_d = state_q;
		edit_head_d = edit_head_q;
		edit_tail_d = edit_tail_q;
		edit_count_d = edit_count_q;
		read_head_d = read_head_q;
		read_tail_d = read_tail_q;
		read_count_d = read_count_q;
		pend_byte_d = pend_byte_q;
		pend_n_d = pend_n_q;
		pend_idx_d = pend_idx_q;
		pend_kind_d = pend_kind_q;
		pend_le_d = pend_le_q;
		rd_v_d = 1'b0;
		edit_we = 1'b0;
		edit_re = 1'b0;
		read_we = 1'b0;
		read_re = 1'b0;
		edit_waddr = edit_tail_q;
		edit_wdata = rx_c;
		edit_raddr = edit_head_q;
		read_waddr = read_tail_q;
		read_wdata = rx_c;
		read_raddr = read_head_q;
		out_load = 1'b0;
		post_b = data_in;
		post_go = 1'b0;
		commit = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pend_idx_d = 2'd0;
					pend_kind_d = tld_pkg::KIND_SENT;
					pend_le_d = 1'b0;
					pend_n_d = 2'd0;
					case (cmd)
						tld_pkg::CMD_RX: begin
							if (canon_q && rx_c == erase_q) begin
								if (edit_count_q != '0) begin
									edit_tail_d = (edit_tail_q == '0) ? LAST_PTR
										: edit_tail_q - 1'b1;
									edit_count_d = edit_count_q - 1'b1;
									if (echoe_q) begin
										pend_byte_d[0] = tld_pkg::CH_BS;
										pend_byte_d[1] = tld_pkg::CH_SP;
										pend_byte_d[2] = tld_pkg::CH_BS;
										pend_n_d = 2'd3;
									end
								end
							end else begin
								post_b = rx_c;
								post_go = echo_q;
								if (canon_q) begin
									if (edit_count_q != FULL_CNT) begin
										edit_we = 1'b1;
										edit_tail_d = (edit_tail_q == LAST_PTR) ? '0
											: edit_tail_q + 1'b1;
										edit_count_d = edit_count_q + 1'b1;
									end
									commit = (rx_c == tld_pkg::CH_LF) || (rx_c == eof_q);
								end else if (read_count_q != FULL_CNT) begin
									read_we = 1'b1;
									read_tail_d = (read_tail_q == LAST_PTR) ? '0
										: read_tail_q + 1'b1;
									read_count_d = read_count_q + 1'b1;
								end
							end
						end
						tld_pkg::CMD_TX: begin
							post_go = 1'b1;
						end
						tld_pkg::CMD_RD: begin
							pend_n_d = 2'd1;
							if (read_count_q != '0) begin
								read_re = 1'b1;
								read_head_d = (read_head_q == LAST_PTR) ? '0
									: read_head_q + 1'b1;
								read_count_d = read_count_q - 1'b1;
								pend_kind_d = tld_pkg::KIND_READ;
							end else begin
								pend_kind_d = tld_pkg::KIND_EMPTY;
								pend_byte_d[0] = '0;
							end
						end
						default: begin
						end
					endcase
					// output post-processing: with OPOST and ONLCR set, LF goes out as CR, LF
					if (post_go) begin
						if (opost_q && onlcr_q && post_b == tld_pkg::CH_LF) begin
							pend_byte_d[0] = tld_pkg::CH_CR;
							pend_byte_d[1] = tld_pkg::CH_LF;
							pend_n_d = 2'd2;
						end else begin
							pend_byte_d[0] = post_b;
							pend_n_d = 2'd1;
						end
					end
					if (read_re)
						state_d = S_RDWAIT;
					else if (commit)
						state_d = S_COMMIT;
					else if (pend_n_d != 2'd0)
						state_d = S_EMIT;
				end
			end
			S_COMMIT: begin
				// byte read last cycle lands in the read ring, dropped when full
				read_wdata = edit_rdata_q;
				if (rd_v_s1 && read_count_q != FULL_CNT) begin
					read_we = 1'b1;
					read_tail_d = (read_tail_q == LAST_PTR) ? '0 : read_tail_q + 1'b1;
					read_count_d = read_count_q + 1'b1;
				end
				if (edit_count_q != '0) begin
					edit_re = 1'b1;
					rd_v_d = 1'b1;
					edit_head_d = (edit_head_q == LAST_PTR) ? '0 : edit_head_q + 1'b1;
					edit_count_d = edit_count_q - 1'b1;
				end else begin
					state_d = (pend_n_q != 2'd0) ? S_EMIT : S_IDLE;
				end
			end
			S_RDWAIT: begin
				pend_byte_d[0] = read_rdata_q;
				pend_le_d = canon_q && (read_rdata_q == tld_pkg::CH_LF);
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					if (pend_idx_q == pend_n_q - 1'b1)
						state_d = S_IDLE;
					else
						pend_idx_d = pend_idx_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			edit_head_q <= '0;
			edit_tail_q <= '0;
			edit_count_q <= '0;
			read_head_q <= '0;
			read_tail_q <= '0;
			read_count_q <= '0;
			pend_n_q <= '0;
			pend_idx_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			map_cr_q <= 1'b1;
			opost_q <= 1'b1;
			onlcr_q <= 1'b1;
			canon_q <= 1'b1;
			echo_q <= 1'b1;
			echoe_q <= 1'b1;
			erase_q <= tld_pkg::ERASE_RST;
			eof_q <= tld_pkg::EOF_RST;
		end else begin
			state_q <= state_d;
			edit_head_q <= edit_head_d;
			edit_tail_q <= edit_tail_d;
			edit_count_q <= edit_count_d;
			read_head_q <= read_head_d;
			read_tail_q <= read_tail_d;
			read_count_q <= read_count_d;
			pend_n_q <= pend_n_d;
			pend_idx_q <= pend_idx_d;
			rd_v_s1 <= rd_v_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					tld_pkg::CFG_MAP_CR: map_cr_q <= cfg_data[0];
					tld_pkg::CFG_OPOST:  opost_q <= cfg_data[0];
					tld_pkg::CFG_ONLCR:  onlcr_q <= cfg_data[0];
					tld_pkg::CFG_CANON:  canon_q <= cfg_data[0];
					tld_pkg::CFG_ECHO:   echo_q <= cfg_data[0];
					tld_pkg::CFG_ECHOE:  echoe_q <= cfg_data[0];
					tld_pkg::CFG_ERASE:  erase_q <= cfg_data;
					tld_pkg::CFG_EOF:    eof_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_byte_q <= pend_byte_d;
		pend_kind_q <= pend_kind_d;
		pend_le_q <= pend_le_d;
		if (out_load) begin
			out_kind_q <= pend_kind_q;
			out_byte_q <= pend_byte_q[pend_idx_q];
			out_le_q <= pend_le_q;
			out_last_q <= (pend_idx_q == pend_n_q - 1'b1);
		end
	end

	// edit ring memory
	always_ff @(posedge clk) begin
		if (edit_we)
			edit_mem[edit_waddr] <= edit_wdata;
		if (edit_re)
			edit_rdata_q <= edit_mem[edit_raddr];
	end

	// read ring memory
	always_ff @(posedge clk) begin
		if (read_we)
			read_mem[read_waddr] <= read_wdata;
		if (read_re)
			read_rdata_q <= read_mem[read_raddr];
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tld_pkg::*;

	// cmd 3 is decoded as nothing; the package has no name for it
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int RING_DEPTH = BUF_DEPTH_DEF;
	// idle cycles before a register write: a line commit may walk up to
	// RING_DEPTH bytes with no result to show for it
	localparam int SETTLE_CYCLES = 300;
	localparam int MAX_SHOWN = 40;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	typedef struct {
		logic [1:0] kind;
		byte_t      value;
		logic       line_end;
		logic       last;
	} tty_result_t;

	// Tracks the edit and read rings plus the register file, and keeps the
	// results each accepted transfer should produce, oldest first.
	class tty_scoreboard;
		byte_t       edit_q[$];
		byte_t       read_q[$];
		tty_result_t due_q[$];
		tty_result_t step_q[$];
		bit          map_cr, opost, onlcr, canon, echo, echoe;
		byte_t       erase_ch, eof_ch;
		int          errors;
		int          shown;

		function new();
			map_cr   = 1'b1;
			opost    = 1'b1;
			onlcr    = 1'b1;
			canon    = 1'b1;
			echo     = 1'b1;
			echoe    = 1'b1;
			erase_ch = ERASE_RST;
			eof_ch   = EOF_RST;
			errors   = 0;
			shown    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, byte_t val);
			case (idx)
				CFG_MAP_CR: map_cr = val[0];
				CFG_OPOST: opost = val[0];
				CFG_ONLCR: onlcr = val[0];
				CFG_CANON: canon = val[0];
				CFG_ECHO: echo = val[0];
				CFG_ECHOE: echoe = val[0];
				CFG_ERASE: erase_ch = val;
				CFG_EOF: eof_ch = val;
				default: ;
			endcase
		endfunction

		function void add_res(logic [1:0] k, byte_t b, logic le);
			tty_result_t r;
			r.kind     = k;
			r.value    = b;
			r.line_end = le;
			r.last     = 1'b0;
			step_q.push_back(r);
		endfunction

		// output post-processing: with opost and onlcr set, LF goes out as CR LF
		function void send_line(byte_t b);
			if (opost && onlcr && b == CH_LF)
				add_res(KIND_SENT, CH_CR, 1'b0);
			add_res(KIND_SENT, b, 1'b0);
		endfunction

		function void take_rx(byte_t d);
			byte_t c;
			byte_t moved;
			c = d;
			if (map_cr && c == CH_CR)
				c = CH_LF;
			if (canon) begin
				if (c == erase_ch) begin
					// erase on an empty line is silent
					if (edit_q.size() > 0) begin
						edit_q.delete(edit_q.size() - 1);
						if (echoe) begin
							add_res(KIND_SENT, CH_BS, 1'b0);
							add_res(KIND_SENT, CH_SP, 1'b0);
							add_res(KIND_SENT, CH_BS, 1'b0);
						end
					end
					return;
				end
				if (echo)
					send_line(c);
				// full edit ring drops the byte but still commits below
				if (edit_q.size() < RING_DEPTH)
					edit_q.push_back(c);
				if (c == CH_LF || c == eof_ch) begin
					while (edit_q.size() > 0) begin
						moved = edit_q.pop_front();
						if (read_q.size() < RING_DEPTH)
							read_q.push_back(moved);
					end
				end
			end else begin
				if (echo)
					send_line(c);
				if (read_q.size() < RING_DEPTH)
					read_q.push_back(c);
			end
		endfunction

		function void pop_reader();
			byte_t b;
			if (read_q.size() > 0) begin
				b = read_q.pop_front();
				add_res(KIND_READ, b, canon && b == CH_LF);
			end else begin
				add_res(KIND_EMPTY, 8'h00, 1'b0);
			end
		endfunction

		function void note_item(logic [1:0] c, byte_t d);
			step_q.delete();
			case (c)
				CMD_RX: take_rx(d);
				CMD_TX: send_line(d);
				CMD_RD: pop_reader();
				default: ;
			endcase
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i])
				due_q.push_back(step_q[i]);
		endfunction

		function int due_count();
			return due_q.size();
		endfunction

		task report(string msg);
			if (shown < MAX_SHOWN)
				$display("ERROR @%0t: %s", $time, msg);
			shown++;
			errors++;
		endtask

		task check_result(tty_result_t got);
			tty_result_t want;
			if (due_q.size() == 0) begin
				report($sformatf("result with nothing pending: kind %0d byte %02h",
					got.kind, got.value));
				return;
			end
			want = due_q.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("out_kind %0d, want %0d", got.kind, want.kind));
			if (got.value !== want.value)
				report($sformatf("out_byte %02h, want %02h", got.value, want.value));
			if (got.line_end !== want.line_end)
				report($sformatf("line_end %b, want %b", got.line_end, want.line_end));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           cmd;
	logic [7:0]           data_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           out_kind;
	logic [7:0]           out_byte;
	logic                 line_end;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	tty_scoreboard sb;
	tty_result_t   seen;
	int            idle_pct;
	int            items_sent;

	terminal_line_discipline_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.line_end  (line_end),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side: values sampled here are the ones before this edge's
	// updates, so a transfer is judged on what the block showed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.kind     = out_kind;
			seen.value    = out_byte;
			seen.line_end = line_end;
			seen.last     = last;
			sb.check_result(seen);
		end
		out_stall <= (idle_pct > 0) && ($urandom_range(0, 99) < idle_pct);
	end

	// One input transfer. Valid stays up from one item to the next unless a
	// gap is drawn, so there is never a drop and raise in the same step.
	task automatic drive_item(logic [1:0] c, byte_t d);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		data_in  <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(c, d);
		if (c != CMD_NOP)
			items_sent++;
	endtask

	// Drop valid, let every pending result arrive, then give a commit walk
	// time to finish so the block is truly idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// caller lowers cfg_valid once the whole burst of writes is done
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, byte_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_config(bit mcr, bit op, bit onl, bit can, bit ech, bit eche,
		byte_t er, byte_t eo);
		write_reg(CFG_MAP_CR, {7'd0, mcr});
		write_reg(CFG_OPOST, {7'd0, op});
		write_reg(CFG_ONLCR, {7'd0, onl});
		write_reg(CFG_CANON, {7'd0, can});
		write_reg(CFG_ECHO, {7'd0, ech});
		write_reg(CFG_ECHOE, {7'd0, eche});
		write_reg(CFG_ERASE, er);
		write_reg(CFG_EOF, eo);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// byte with a lean toward the characters the discipline reacts to
	function automatic byte_t pick_byte();
		case ($urandom_range(0, 9))
			0: return CH_LF;
			1: return CH_CR;
			2: return sb.erase_ch;
			3: return sb.eof_ch;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly whole lines (typed bytes, some erases, a terminator, then reads
	// to drain them), mixed with writes, stray reads and raw noise.
	task automatic run_mix(int n);
		int start_cnt;
		int len;
		int r;
		start_cnt = items_sent;
		while (items_sent - start_cnt < n) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				len = $urandom_range(0, 10);
				repeat (len) begin
					if ($urandom_range(0, 7) == 0)
						drive_item(CMD_RX, sb.erase_ch);
					else
						drive_item(CMD_RX, byte_t'($urandom_range(0, 255)));
				end
				case ($urandom_range(0, 2))
					0: drive_item(CMD_RX, CH_LF);
					1: drive_item(CMD_RX, CH_CR);
					default: drive_item(CMD_RX, sb.eof_ch);
				endcase
				repeat (len + $urandom_range(0, 2))
					drive_item(CMD_RD, byte_t'($urandom_range(0, 255)));
			end else if (r < 70) begin
				drive_item(CMD_TX, pick_byte());
			end else if (r < 85) begin
				drive_item(CMD_RD, byte_t'($urandom_range(0, 255)));
			end else begin
				drive_item(2'($urandom_range(0, 3)), pick_byte());
			end
		end
	endtask

	initial begin
		sb         = new();
		idle_pct   = 0;
		items_sent = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_NOP;
		data_in   <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MAP_CR;
		cfg_data  <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 30;

		// directed pass on reset settings
		drive_item(CMD_NOP, 8'hFF);          // unused command, no result
		drive_item(CMD_RD, 8'h00);           // read on empty ring
		drive_item(CMD_TX, CH_LF);           // CR LF expansion
		drive_item(CMD_TX, 8'h41);
		drive_item(CMD_RX, ERASE_RST);       // erase with nothing typed
		drive_item(CMD_RX, 8'h68);
		drive_item(CMD_RX, 8'h69);
		drive_item(CMD_RX, ERASE_RST);       // BS SP BS echo
		drive_item(CMD_RX, CH_CR);           // mapped to LF, commits
		drive_item(CMD_RD, 8'hFF);
		drive_item(CMD_RD, 8'h55);           // LF with line_end
		drive_item(CMD_RD, 8'hAA);           // empty again
		drive_item(CMD_RX, 8'h00);
		drive_item(CMD_RX, 8'hFF);
		drive_item(CMD_RX, EOF_RST);         // eof commits the line
		drive_item(CMD_RD, 8'h00);
		drive_item(CMD_RD, 8'h00);
		drive_item(CMD_RD, 8'h00);
		drive_item(CMD_TX, 8'h00);
		drive_item(CMD_TX, 8'hFF);
		drive_item(CMD_NOP, 8'h00);
		drive_item(CMD_TX, CH_CR);
		settle();

		// low extremes: raw mode, everything off
		apply_config(0, 0, 0, 0, 0, 0, 8'h00, 8'h00);
		run_mix(40);
		settle();

		// high extremes for the control characters
		apply_config(0, 1, 0, 1, 1, 0, 8'hFF, 8'hFF);
		run_mix(40);
		settle();

		// eof equal to LF, backspace as erase, no echo; no idling here
		idle_pct = 0;
		apply_config(1, 0, 1, 1, 0, 1, CH_BS, CH_LF);
		run_mix(40);
		settle();
		idle_pct = 30;

		apply_config(1, 1, 1, 0, 1, 1, byte_t'($urandom_range(0, 255)),
			byte_t'($urandom_range(0, 255)));
		run_mix(40);
		settle();

		// erase and eof on the same byte: erase wins
		begin
			byte_t same;
			same = byte_t'($urandom_range(0, 255));
			apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), same, same);
		end
		run_mix(40);
		settle();

		apply_config(1, 1, 1, 1, 1, 1, ERASE_RST, EOF_RST);
		run_mix(40);
		settle();

		if (sb.errors == 0 && sb.due_count() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
